// ===== rtl/time_bin_average_decimator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Time-bin average decimator: assertion macros
// Shared concurrent assertion forms for the decimator's RTL.
// ----------------------------------------------------------------------------
`ifndef TIME_BIN_AVERAGE_DECIMATOR_TOP_DEFINES_SVH
`define TIME_BIN_AVERAGE_DECIMATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBAD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBAD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tbad_pkg.sv =====
// ----------------------------------------------------------------------------
// Time-bin average decimator package
// Widths, the closed-bin record type and the queue control structures.
// ----------------------------------------------------------------------------
package tbad_pkg;

    localparam int COUNT_BITS = 16;
    localparam int TIME_BITS  = 48;

    localparam int IN_TIME_W  = 48;
    localparam int VALUE_W    = 32;
    localparam int START_W    = 49;
    localparam int END_W      = START_W + 1;
    localparam int TSUM_W     = 64;
    localparam int VSUM_W     = 48;
    localparam int WIDTH_W    = 32;
    localparam int SAMPLES_W  = 16;
    localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET = 32'd1000;

    localparam int DIV_STEPS  = TSUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 2;

    typedef logic [COUNT_BITS-1:0] count_t;

    // One closed bin waiting for its means.
    typedef struct packed {
        logic                     last;
        logic                     done;
        logic                     ovf;
        count_t                   cnt;
        logic signed [VSUM_W-1:0] vsum;
        logic [TSUM_W-1:0]        tsum;
    } bin_rec_t;

    typedef struct packed {
        logic     push_a;
        logic     push_b;
        bin_rec_t rec_a;
        bin_rec_t rec_b;
    } q_push_t;

    typedef struct packed {
        logic [QPTR_W:0] level;
        logic            empty;
        logic            room2;
    } q_stat_t;

    // Sample count clipped to the width of the bin_samples field.
    function automatic logic [SAMPLES_W-1:0] sat_samples(input count_t n);
        logic [31:0] w;
        begin
            w = 32'(n);
            return (w > 32'h0000_FFFF) ? 16'hFFFF : w[SAMPLES_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/tbad_front.sv =====
// ----------------------------------------------------------------------------
// Time-bin average decimator: front end
// Accepts samples, keeps the open bin's sums and queues every closed bin.
// ----------------------------------------------------------------------------
module tbad_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [tbad_pkg::WIDTH_W-1:0]   cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tbad_pkg::IN_TIME_W-1:0] in_time,
    input  logic signed [tbad_pkg::VALUE_W-1:0] in_value,
    input  logic                           in_eot,
    input  tbad_pkg::q_stat_t              q_stat,
    output tbad_pkg::q_push_t              q_push
);
    import tbad_pkg::*;

    logic [WIDTH_W-1:0]        bin_width_reg;
    logic [START_W-1:0]        bin_start_reg, bin_start_next;
    logic [TSUM_W-1:0]         time_sum_reg, time_sum_next;
    logic signed [VSUM_W-1:0]  value_sum_reg, value_sum_next;
    count_t                    count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic                      open_reg, open_next;
    logic                      accept;

    assign in_ready = q_stat.room2;
    assign accept   = in_valid && q_stat.room2;

    always_comb
    begin
        logic [TIME_BITS-1:0]      t;
        logic [START_W-1:0]        bs;
        logic [TSUM_W-1:0]         ts;
        logic signed [VSUM_W-1:0]  vs;
        count_t                    cnt;
        logic                      ovf;
        logic [END_W-1:0]          bin_end;
        logic                      in_bin;
        logic [TSUM_W:0]           tadd;
        logic signed [VSUM_W:0]    vadd;
        logic                      drop;

        t       = in_time[TIME_BITS-1:0];
        bs      = open_reg ? bin_start_reg : START_W'(t);
        ts      = open_reg ? time_sum_reg : '0;
        vs      = open_reg ? value_sum_reg : '0;
        cnt     = open_reg ? count_reg : '0;
        ovf     = open_reg ? ovf_reg : 1'b0;
        bin_end = {1'b0, bs} + END_W'(bin_width_reg);
        in_bin  = END_W'(t) < bin_end;
        tadd    = {1'b0, ts} + (TSUM_W + 1)'(t);
        vadd    = {vs[VSUM_W-1], vs} + (VSUM_W + 1)'(in_value);
        drop    = (cnt == '1) || tadd[TSUM_W] || (vadd[VSUM_W] != vadd[VSUM_W-1]);

        q_push.push_a     = 1'b0;
        q_push.rec_a.last = 1'b0;
        q_push.rec_a.done = 1'b0;
        q_push.rec_a.ovf  = ovf;
        q_push.rec_a.cnt  = cnt;
        q_push.rec_a.vsum = vs;
        q_push.rec_a.tsum = ts;

        if (in_bin)
        begin
            if (drop)
            begin
                ovf = 1'b1;
            end
            else
            begin
                ts  = tadd[TSUM_W-1:0];
                vs  = vadd[VSUM_W-1:0];
                cnt = cnt + count_t'(1);
            end
        end
        else
        begin
            q_push.push_a = (cnt != '0);
            bs  = bs + START_W'(bin_width_reg);
            ts  = TSUM_W'(t);
            vs  = VSUM_W'(in_value);
            cnt = count_t'(1);
            ovf = 1'b0;
        end

        q_push.push_b     = in_eot && (cnt != '0);
        q_push.rec_b.last = 1'b1;
        q_push.rec_b.done = 1'b1;
        q_push.rec_b.ovf  = ovf;
        q_push.rec_b.cnt  = cnt;
        q_push.rec_b.vsum = vs;
        q_push.rec_b.tsum = ts;
        q_push.rec_a.last = !q_push.push_b;

        if (!accept)
        begin
            q_push.push_a = 1'b0;
            q_push.push_b = 1'b0;
        end

        if (in_eot)
        begin
            bin_start_next = '0;
            time_sum_next  = '0;
            value_sum_next = '0;
            count_next     = '0;
            ovf_next       = 1'b0;
            open_next      = 1'b0;
        end
        else
        begin
            bin_start_next = bs;
            time_sum_next  = ts;
            value_sum_next = vs;
            count_next     = cnt;
            ovf_next       = ovf;
            open_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg <= BIN_WIDTH_RESET;
            bin_start_reg <= '0;
            time_sum_reg  <= '0;
            value_sum_reg <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            open_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                bin_width_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                bin_start_reg <= bin_start_next;
                time_sum_reg  <= time_sum_next;
                value_sum_reg <= value_sum_next;
                count_reg     <= count_next;
                ovf_reg       <= ovf_next;
                open_reg      <= open_next;
            end
        end
    end

endmodule

// ===== rtl/tbad_queue.sv =====
// ----------------------------------------------------------------------------
// Time-bin average decimator: bin queue
// Short queue of closed bins, two writes and one read per cycle.
// ----------------------------------------------------------------------------
module tbad_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  tbad_pkg::q_push_t  q_push,
    input  logic               pop,
    output tbad_pkg::bin_rec_t rd_rec,
    output tbad_pkg::q_stat_t  q_stat
);
    import tbad_pkg::*;

    bin_rec_t          mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   level_reg, level_next;
    logic [1:0]        n_push;
    bin_rec_t          slot0;

    assign n_push = 2'(q_push.push_a) + 2'(q_push.push_b);
    assign slot0  = q_push.push_a ? q_push.rec_a : q_push.rec_b;

    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
    assign level_next  = level_reg + (QPTR_W + 1)'(n_push) - (QPTR_W + 1)'(pop);

    assign rd_rec       = mem[rd_ptr_reg];
    assign q_stat.level = level_reg;
    assign q_stat.empty = (level_reg == '0);
    assign q_stat.room2 = (level_reg <= (QPTR_W + 1)'(QDEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            mem[wr_ptr_reg] <= slot0;
        end
        if (n_push == 2'd2)
        begin
            mem[wr_ptr_reg + QPTR_W'(1)] <= q_push.rec_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            level_reg  <= level_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

endmodule

// ===== rtl/tbad_back.sv =====
// ----------------------------------------------------------------------------
// Time-bin average decimator: back end
// Divides a closed bin's sums by its count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tbad_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  tbad_pkg::bin_rec_t              rd_rec,
    input  logic                            q_empty,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tbad_pkg::OUT_DATA_W-1:0] out_data,
    output logic [tbad_pkg::OUT_USER_W-1:0] out_user,
    output logic                            out_last
);
    import tbad_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg;
    logic [TSUM_W-1:0]     tq_reg, tq_next;
    logic [TSUM_W-1:0]     vq_reg, vq_next;
    count_t                trem_reg, trem_next;
    count_t                vrem_reg, vrem_next;
    count_t                den_reg;
    logic                  neg_reg, ovf_reg, last_reg, done_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;
    logic                  out_last_reg;
    logic                  load_out;
    logic [VALUE_W-1:0]    vq_low;
    logic [VALUE_W-1:0]    avg_value;
    logic [VSUM_W-1:0]     mag;

    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign mag      = rd_rec.vsum[VSUM_W-1] ? (VSUM_W'(0) - rd_rec.vsum) : rd_rec.vsum;
    assign vq_low   = vq_reg[VALUE_W-1:0];
    assign avg_value = neg_reg ? (VALUE_W'(0) - vq_low) : vq_low;

    // Restoring division step for both quotients against the same count.
    always_comb
    begin
        logic [COUNT_BITS:0] tsh;
        logic [COUNT_BITS:0] vsh;
        logic                tge;
        logic                vge;

        tsh       = {trem_reg, tq_reg[TSUM_W-1]};
        vsh       = {vrem_reg, vq_reg[TSUM_W-1]};
        tge       = tsh >= {1'b0, den_reg};
        vge       = vsh >= {1'b0, den_reg};
        trem_next = tge ? COUNT_BITS'(tsh - {1'b0, den_reg}) : tsh[COUNT_BITS-1:0];
        vrem_next = vge ? COUNT_BITS'(vsh - {1'b0, den_reg}) : vsh[COUNT_BITS-1:0];
        tq_next   = {tq_reg[TSUM_W-2:0], tge};
        vq_next   = {vq_reg[TSUM_W-2:0], vge};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tq_reg   <= rd_rec.tsum;
            vq_reg   <= TSUM_W'(mag);
            trem_reg <= '0;
            vrem_reg <= '0;
            den_reg  <= rd_rec.cnt;
            neg_reg  <= rd_rec.vsum[VSUM_W-1];
            ovf_reg  <= rd_rec.ovf;
            last_reg <= rd_rec.last;
            done_reg <= rd_rec.done;
        end
        else if (state_reg == ST_DIV)
        begin
            tq_reg   <= tq_next;
            vq_reg   <= vq_next;
            trem_reg <= trem_next;
            vrem_reg <= vrem_next;
        end
        if (load_out)
        begin
            out_data_reg <= {sat_samples(den_reg), avg_value, tq_reg[IN_TIME_W-1:0]};
            out_user_reg <= {done_reg, ovf_reg};
            out_last_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/time_bin_average_decimator_top.sv =====
// ----------------------------------------------------------------------------
// Time-bin average decimator, top level
// Averages a track of timestamped samples over fixed-width time bins.
// ----------------------------------------------------------------------------
// Samples enter on the s_axis stream, one beat per sample; tlast marks the
// last sample of a track and closes it. Each closed bin leaves on m_axis as
// one beat carrying its mean time, mean value and sample count; tlast marks
// the last result caused by one input beat, tuser flags dropped samples and
// the final bin of a track. A sample causes none, one or two results. The
// user writes the bin width through cfg_wr_en and cfg_wr_data, only while
// idle; the block itself does not enforce this.
// The front end takes one sample a cycle as long as the four-entry bin queue
// has room for two records. The back end works through the queue with a
// radix-2 divider of 64 steps; for each result it takes the record from the
// queue, runs the 64 divide steps and loads the output register. It takes
// the next record from the queue only once the last result has been loaded.
// A stalled receiver holds the output register; the divider and then the
// queue fill, after which s_axis tready falls. Reset clears all control
// state, closes any open track and loads a bin width of 1000; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`include "time_bin_average_decimator_top_defines.svh"

module time_bin_average_decimator_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tbad_pkg::WIDTH_W-1:0]      cfg_wr_data,     // bin_width
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tbad_pkg::IN_DATA_W-1:0]    s_axis_tdata,    // sample_time, sample_value
    input  logic                              s_axis_tlast,    // end_of_track
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tbad_pkg::OUT_DATA_W-1:0]   m_axis_tdata,    // avg_time, avg_value, bin_samples
    output logic [tbad_pkg::OUT_USER_W-1:0]   m_axis_tuser,    // count_saturated, track_done
    output logic                              m_axis_tlast     // last_of_run
);
    import tbad_pkg::*;

    q_push_t  q_push;
    q_stat_t  q_stat;
    bin_rec_t rd_rec;
    logic     pop;

    // The front end owns the bin width register and the open bin's sums.
    tbad_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_time     (s_axis_tdata[IN_TIME_W-1:0]),
        .in_value    (s_axis_tdata[IN_TIME_W+VALUE_W-1:IN_TIME_W]),
        .in_eot      (s_axis_tlast),
        .q_stat      (q_stat),
        .q_push      (q_push)
    );

    // Closed bins wait here so that accumulation waits on division only once the queue is short of room.
    tbad_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (pop),
        .rd_rec (rd_rec),
        .q_stat (q_stat)
    );

    // The back end forms the means and drives the result beat.
    tbad_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_rec    (rd_rec),
        .q_empty   (q_stat.empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    // A track's end always closes a bin that holds at least one sample.
    `TBAD_ASSERT_SAME(a_eot_emits, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, q_push.push_b, "end of track closed no bin")

    // In the cycle after, the queue is not empty or the back end is not popping.
    `TBAD_ASSERT_NEXT(a_eot_queued, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !q_stat.empty || pop == 1'b0, "closed bin missing from queue")

    // The queue never holds more records than it has entries.
    `TBAD_ASSERT_SAME(a_queue_bound, clk, rst_n, 1'b1, q_stat.level <= (QPTR_W + 1)'(QDEPTH), "bin queue overflow")

    // The final bin of a track is always the last result of its beat.
    `TBAD_ASSERT_SAME(a_done_last, clk, rst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast, "track end without tlast")

endmodule

// ===== test/tb_time_bin_average_decimator_top.sv =====
// ----------------------------------------------------------------------------
// Time-bin average decimator testbench
// Drives tracks of timestamped samples into the decimator, predicts every
// closed bin and checks each result beat against that prediction.
// ----------------------------------------------------------------------------
// The sample stream goes in on s_axis and the bin means come back on m_axis.
// The testbench keeps its own model of the open bin (start, sums, count and
// the dropped-sample flag). Each accepted sample beat is folded into that
// model, and every bin that the sample closes is queued as an expected result.
// A separate process takes result beats and compares them, field by field,
// with the oldest queued bin.
//
// The tests run in this order:
//   - bin closing at the reset width: joining, closing, gaps, earlier times,
//     end of track with one and with two results;
//   - extreme bin widths and truncation of the means;
//   - a long receiver hold-off, so that the block fills and stalls its input;
//   - random tracks under several bin widths and idling patterns.
// The bin width is only rewritten once every expected result has arrived and
// the divider has had time to empty.
// ----------------------------------------------------------------------------

module tb_time_bin_average_decimator_top;

    import tbad_pkg::*;

    // Largest count that a bin can hold before further samples are dropped.
    localparam int          COUNT_LIMIT     = (1 << COUNT_BITS) - 1;
    localparam logic [47:0] TIME_MAX        = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] START_MASK      = (64'd1 << START_W) - 64'd1;
    localparam longint      VALUE_SUM_HI    = 64'sd140737488355327;
    localparam longint      VALUE_SUM_LO    = -64'sd140737488355328;
    // Idle wait after the last result; it covers one divider pass with margin.
    localparam int          DRAIN_CYCLES    = 200;
    localparam int          HOLD_CYCLES     = 800;
    localparam int          CYCLE_LIMIT     = 2_000_000;
    localparam int          ERROR_PRINT_MAX = 40;

    // One closed bin as it should appear on m_axis.
    typedef struct packed {
        logic [47:0] avg_time;
        logic [31:0] avg_value;
        logic [15:0] bin_samples;
        logic        saturated;
        logic        track_done;
        logic        run_last;
    } bin_mean_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [WIDTH_W-1:0]    cfg_wr_data   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // sample_time, sample_value
    logic                  s_axis_tlast  = 1'b0;  // end_of_track
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;          // avg_time, avg_value, bin_samples
    logic [OUT_USER_W-1:0] m_axis_tuser;          // count_saturated, track_done
    logic                  m_axis_tlast;          // last_of_run

    // Bins that have been closed by accepted samples but not yet seen.
    bin_mean_t pending_bins [$];

    // Model of the bin being built.
    logic [31:0] model_width  = BIN_WIDTH_RESET;
    logic [63:0] open_start   = '0;
    logic [63:0] time_total   = '0;
    longint      value_total  = 0;
    int          model_count  = 0;
    logic        bin_dropped  = 1'b0;
    logic        track_active = 1'b0;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   samples_sent   = 0;
    int   error_count    = 0;
    int   cycle_count    = 0;
    logic hold_go        = 1'b0;
    int   hold_count     = 0;
    logic holding;

    time_bin_average_decimator_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Guard against a block that stops producing beats.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[time_bin_average_decimator_top] ERROR");
            $finish;
        end
    end

    // The receiver hold-off is counted here, once it has been started.
    assign holding = hold_go && (hold_count < HOLD_CYCLES);

    always @(posedge clk)
    begin
        if (holding)
        begin
            hold_count <= hold_count + 1;
        end
    end

    task automatic report_mismatch(input string what);
        if (error_count < ERROR_PRINT_MAX)
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
        error_count++;
    endtask

    // Means of the open bin. Both divisions truncate toward zero.
    function automatic bin_mean_t bin_means(input logic done);
        bin_mean_t r;
        longint    quot;
        quot          = value_total / longint'(model_count);
        r.avg_time    = 48'(time_total / 64'(model_count));
        r.avg_value   = 32'(quot);
        r.bin_samples = (model_count > 65535) ? 16'hFFFF : 16'(model_count);
        r.saturated   = bin_dropped;
        r.track_done  = done;
        r.run_last    = 1'b0;
        return r;
    endfunction

    // Fold one accepted sample into the bin model and queue every bin it closes.
    task automatic fold_sample(input logic [47:0] stamp_in, input logic [31:0] value_in,
                               input logic eot);
        logic [63:0]        stamp;
        logic signed [31:0] value_s;
        longint             value;
        longint             next_sum;
        bin_mean_t          closed [2];
        int                 n;
        stamp   = 64'(stamp_in);
        value_s = value_in;
        value   = value_s;
        n       = 0;

        if (!track_active)
        begin
            track_active = 1'b1;
            open_start   = stamp;
            time_total   = '0;
            value_total  = 0;
            model_count  = 0;
            bin_dropped  = 1'b0;
        end

        if (stamp < open_start + 64'(model_width))
        begin
            next_sum = value_total + value;
            if (model_count >= COUNT_LIMIT || time_total > ~64'd0 - stamp ||
                next_sum > VALUE_SUM_HI || next_sum < VALUE_SUM_LO)
            begin
                bin_dropped = 1'b1;
            end
            else
            begin
                time_total  = time_total + stamp;
                value_total = next_sum;
                model_count++;
            end
        end
        else
        begin
            if (model_count != 0)
            begin
                closed[n] = bin_means(1'b0);
                n++;
            end
            // The start moves by exactly one width, however far the sample jumped.
            open_start  = (open_start + 64'(model_width)) & START_MASK;
            time_total  = stamp;
            value_total = value;
            model_count = 1;
            bin_dropped = 1'b0;
        end

        if (eot)
        begin
            if (model_count != 0)
            begin
                closed[n] = bin_means(1'b1);
                n++;
            end
            track_active = 1'b0;
            open_start   = '0;
            time_total   = '0;
            value_total  = 0;
            model_count  = 0;
            bin_dropped  = 1'b0;
        end

        for (int i = 0; i < n; i++)
        begin
            closed[i].run_last = (i == n - 1);
            pending_bins.insert(pending_bins.size(), closed[i]);
        end
    endtask

    // Offer one sample beat, with random idle cycles in front of it, and wait
    // until it is taken. Returns at the edge where the beat was accepted.
    task automatic send_sample(input logic [47:0] stamp, input logic [31:0] value,
                               input logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {16'($urandom), $urandom, $urandom};
            s_axis_tlast  <= 1'($urandom);
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, stamp};
        s_axis_tlast  <= eot;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        fold_sample(stamp, value, eot);
        samples_sent++;
    endtask

    task automatic lower_valid();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
    endtask

    // Wait until every expected bin has come back and the divider is empty.
    task automatic wait_idle();
        while (pending_bins.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_bin_width(input logic [31:0] width);
        lower_valid();
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= width;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_width = width;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Result checker: one beat per closed bin, in order.
    always @(posedge clk)
    begin : result_check
        bin_mean_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_bins.size() == 0)
                begin
                    report_mismatch($sformatf("result beat with no bin expected, tdata %h",
                                              m_axis_tdata));
                end
                else
                begin
                    want = pending_bins.pop_front();
                    if (m_axis_tdata[47:0] !== want.avg_time)
                        report_mismatch($sformatf("avg_time %h, expected %h",
                                                  m_axis_tdata[47:0], want.avg_time));
                    if (m_axis_tdata[79:48] !== want.avg_value)
                        report_mismatch($sformatf("avg_value %h, expected %h",
                                                  m_axis_tdata[79:48], want.avg_value));
                    if (m_axis_tdata[95:80] !== want.bin_samples)
                        report_mismatch($sformatf("bin_samples %0d, expected %0d",
                                                  m_axis_tdata[95:80], want.bin_samples));
                    if (m_axis_tuser[0] !== want.saturated)
                        report_mismatch($sformatf("count_saturated %b, expected %b",
                                                  m_axis_tuser[0], want.saturated));
                    if (m_axis_tuser[1] !== want.track_done)
                        report_mismatch($sformatf("track_done %b, expected %b",
                                                  m_axis_tuser[1], want.track_done));
                    if (m_axis_tlast !== want.run_last)
                        report_mismatch($sformatf("last_of_run %b, expected %b",
                                                  m_axis_tlast, want.run_last));
                end
            end
            m_axis_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Bin closing at the reset width of 1000.
    task automatic test_bin_closing();
        set_idling(0, 0);
        send_sample(48'd100, 32'h7FFF_FFFF, 1'b0);   // opens the track at 100
        send_sample(48'd500, 32'h8000_0000, 1'b0);
        send_sample(48'd50, 32'hFFFF_FFFF, 1'b0);     // earlier than the start, joins
        send_sample(48'd1100, 32'h0001_0000, 1'b0);   // exactly on the bin end
        send_sample(48'd5000, 32'hFFFF_0000, 1'b0);   // gap of several widths
        send_sample(48'd2500, 32'h1234_5678, 1'b0);
        send_sample(48'd9000, 32'h0000_0003, 1'b1);   // closes one bin and flushes another
        send_sample(48'd7, 32'h8000_0001, 1'b1);      // opens and ends a track alone
        send_sample(48'd0, 32'h8000_0000, 1'b0);
        send_sample(48'd0, 32'h8000_0000, 1'b0);
        send_sample(48'd999, 32'h7FFF_FFFF, 1'b0);
        send_sample(TIME_MAX, 32'h7FFF_FFFF, 1'b1);
        lower_valid();
        wait_idle();
    endtask

    // Narrowest and widest bins, and truncation of negative means.
    task automatic test_width_extremes();
        write_bin_width(32'd1);
        send_sample(48'd5, 32'd1, 1'b0);
        send_sample(48'd5, 32'd2, 1'b0);
        send_sample(48'd6, 32'd3, 1'b0);
        send_sample(48'd6, -32'sd5, 1'b0);
        send_sample(48'd7, 32'd0, 1'b1);
        // The bin end lies beyond the 48-bit time range here.
        write_bin_width(32'hFFFF_FFFF);
        send_sample(TIME_MAX, 32'h7FFF_FFFF, 1'b0);
        send_sample(48'd0, 32'h8000_0000, 1'b0);
        send_sample(TIME_MAX, 32'd1, 1'b1);
        write_bin_width(32'd3);
        send_sample(48'd10, 32'hFFFF_FFFF, 1'b0);
        send_sample(48'd11, 32'hFFFF_FFFE, 1'b0);
        send_sample(48'd13, 32'd0, 1'b1);
        lower_valid();
        wait_idle();
    endtask

    // Each sample after the first closes a bin while the receiver holds off, so the bin queue
    // fills and s_axis tready has to fall.
    task automatic test_backpressure();
        logic [47:0] base;
        set_idling(0, 0);
        write_bin_width(32'd1);
        base = 48'({$urandom, $urandom}) >> 1;
        hold_go <= 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            send_sample(base + 48'(i), $urandom, i == 39);
        end
        lower_valid();
        wait_idle();
    endtask

    // One track: mostly nondecreasing times with steps inside the bin, across
    // it, across several widths or right on its end; sometimes earlier times
    // and sometimes no end-of-track mark.
    task automatic send_random_track(input logic [31:0] width);
        int          len;
        logic [47:0] stamp;
        logic [63:0] next;
        logic [31:0] value;
        logic        eot;
        len   = $urandom_range(40, 1);
        stamp = 48'({$urandom, $urandom});
        if ($urandom_range(2) == 0)
        begin
            stamp = 48'($urandom_range(5000));
        end
        for (int i = 0; i < len; i++)
        begin
            value = $urandom;
            if ($urandom_range(7) == 0)
            begin
                case ($urandom_range(3))
                    0:       value = 32'h7FFF_FFFF;
                    1:       value = 32'h8000_0000;
                    2:       value = 32'h0000_0000;
                    default: value = 32'hFFFF_FFFF;
                endcase
            end
            eot = (i == len - 1) && ($urandom_range(9) != 0);
            send_sample(stamp, value, eot);
            case ($urandom_range(9))
                0:          next = 64'(stamp);
                1, 2, 3, 4: next = 64'(stamp) + 64'($urandom) % (64'(width) / 4 + 1);
                5:          next = 64'(stamp) + 64'(width) + 64'($urandom) % (64'(width) + 1);
                6:          next = 64'(stamp) + 64'(width) * 64'($urandom_range(5, 2));
                7:          next = open_start + 64'(width);
                8:          next = open_start + 64'(width) - 64'd1;
                default:    next = 64'(stamp) -
                                   64'($urandom_range(2000)) % (64'(stamp) + 64'd1);
            endcase
            stamp = (next > 64'(TIME_MAX)) ? TIME_MAX : next[47:0];
        end
    endtask

    task automatic test_random_tracks();
        logic [31:0] width;
        int          first;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       width = 32'd1000;
                1:       width = 32'd1;
                2:       width = 32'd37;
                3:       width = 32'hFFFF_FFFF;
                4:       width = 32'd3;
                5:       width = 32'd50000;
                default: width = $urandom_range(32'hFFFF_FFFF, 1);
            endcase
            write_bin_width(width);
            case (p % 4)
                0:       set_idling(0, 0);
                1:       set_idling(88, 0);
                2:       set_idling(0, 88);
                default: set_idling(7, 7);
            endcase
            first = samples_sent;
            while (samples_sent - first < 120)
            begin
                send_random_track(width);
            end
        end
        lower_valid();
        wait_idle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bin_closing();
        test_width_extremes();
        test_backpressure();
        test_random_tracks();

        if (error_count == 0)
        begin
            $display("[time_bin_average_decimator_top] OK");
        end
        else
        begin
            $display("[time_bin_average_decimator_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tbad_pkg.sv
rtl/tbad_front.sv
rtl/tbad_queue.sv
rtl/tbad_back.sv
rtl/time_bin_average_decimator_top.sv
test/tb_time_bin_average_decimator_top.sv
